@@ rtl/core/accel_tilt_roll_pitch_defines.svh @@
// assertion macros shared by the checker
`ifndef ACCEL_TILT_ROLL_PITCH_DEFINES_SVH
`define ACCEL_TILT_ROLL_PITCH_DEFINES_SVH

// implication checked on every clock outside reset
`define ATRP_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ATRP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/core/atrp_pkg.sv @@
`timescale 1ns / 1ps
package atrp_pkg;
    localparam int SAMPLE_WIDTH  = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int N_STAGES      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    // datapath: samples scaled to 2^26 full scale, growth by cordic gain and sign
    localparam int DW            = 30;
    localparam int AW            = 26;
    localparam int ROLL_W        = 16;
    localparam int PITCH_W       = 15;
    localparam int STAGE_IDX_W   = $clog2(TABLE_LEN);
    localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;
    localparam logic signed [AW-1:0] DEG180_Q16 = AW'(180 * 65536);
    localparam logic signed [ROLL_W:0]  ROLL_MAX  = 17'sd23040;
    localparam logic signed [PITCH_W:0] PITCH_MAX = 16'sd11520;

    typedef logic signed [DW-1:0] t_vec;
    typedef logic signed [AW-1:0] t_ang;

    typedef struct packed {
        logic valid;
        t_vec x;
        t_vec y;
        t_ang acc;
    } t_cordic;

    function automatic t_ang atan_q16(input logic [STAGE_IDX_W-1:0] i);
        case (i)
            5'd0:  atan_q16 = 26'sd2949120;
            5'd1:  atan_q16 = 26'sd1740967;
            5'd2:  atan_q16 = 26'sd919879;
            5'd3:  atan_q16 = 26'sd466945;
            5'd4:  atan_q16 = 26'sd234379;
            5'd5:  atan_q16 = 26'sd117304;
            5'd6:  atan_q16 = 26'sd58666;
            5'd7:  atan_q16 = 26'sd29335;
            5'd8:  atan_q16 = 26'sd14668;
            5'd9:  atan_q16 = 26'sd7334;
            5'd10: atan_q16 = 26'sd3667;
            5'd11: atan_q16 = 26'sd1833;
            5'd12: atan_q16 = 26'sd917;
            5'd13: atan_q16 = 26'sd458;
            5'd14: atan_q16 = 26'sd229;
            5'd15: atan_q16 = 26'sd115;
            5'd16: atan_q16 = 26'sd57;
            5'd17: atan_q16 = 26'sd29;
            5'd18: atan_q16 = 26'sd14;
            5'd19: atan_q16 = 26'sd7;
            5'd20: atan_q16 = 26'sd4;
            5'd21: atan_q16 = 26'sd2;
            5'd22: atan_q16 = 26'sd1;
            default: atan_q16 = 26'sd0;
        endcase
    endfunction
endpackage

@@ rtl/core/accel_tilt_roll_pitch.sv @@
`timescale 1ns / 1ps
// pipeline: input register, roll cordic stages, gain multiply register, pitch cordic stages, output register
// throughput: one beat per cycle while the output is not stalled, set by the unrolled cordic stages
// the whole pipe stalls when the output register holds a beat not taken
// reset: synchronous active low, clears all valid bits
module accel_tilt_roll_pitch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // accel_x[13:0], accel_y[27:14], accel_z[41:28]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // roll_angle[15:0], pitch_angle[30:16]
);
    import atrp_pkg::*;

    localparam int SHIFT = 26 - SAMPLE_WIDTH;
    localparam int LAT_X = N_STAGES;

    logic    w_en;
    t_cordic w_in0, w_roll_out, w_pitch_in, w_pitch_out;
    t_vec    w_ax, w_ay, w_az;
    t_cordic r_in;
    t_vec    r_ax_in;
    t_vec    r_ax_dly [LAT_X];
    t_ang    r_roll_dly [N_STAGES];
    t_ang    w_roll_acc;
    logic    r_out_valid;
    logic signed [ROLL_W-1:0]  r_roll;
    logic signed [PITCH_W-1:0] r_pitch;
    logic signed [AW-10:0]     w_rq, w_pq;
    logic signed [ROLL_W-1:0]  w_rs;
    logic signed [PITCH_W-1:0] w_ps;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // sign extend and scale the samples
    assign w_ax = DW'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])) <<< SHIFT;
    assign w_ay = DW'($signed(s_axis_tdata[14+SAMPLE_WIDTH-1:14])) <<< SHIFT;
    assign w_az = DW'($signed(s_axis_tdata[28+SAMPLE_WIDTH-1:28])) <<< SHIFT;

    // quadrant fold for negative z
    always_comb begin
        w_in0.valid = s_axis_tvalid;
        w_in0.x     = w_az;
        w_in0.y     = w_ay;
        w_in0.acc   = '0;
        if (w_az[DW-1]) begin
            w_in0.x   = -w_az;
            w_in0.y   = -w_ay;
            w_in0.acc = w_ay[DW-1] ? -DEG180_Q16 : DEG180_Q16;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in    <= w_in0;
            r_ax_in <= w_ax;
        end
    end

    atrp_cordic u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_data  (r_in),
        .o_data  (w_roll_out)
    );

    // x travels alongside the roll pass
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < LAT_X; i++) begin
                r_ax_dly[i] <= (i == 0) ? r_ax_in : r_ax_dly[(i == 0) ? 0 : i - 1];
            end
        end
    end

    atrp_gain u_gain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_roll     (w_roll_out),
        .i_ax       (r_ax_dly[LAT_X-1]),
        .o_pitch    (w_pitch_in),
        .o_roll_acc (w_roll_acc)
    );

    atrp_cordic u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_data  (w_pitch_in),
        .o_data  (w_pitch_out)
    );

    // roll angle waits for the pitch pass
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < N_STAGES; i++) begin
                r_roll_dly[i] <= (i == 0) ? w_roll_acc : r_roll_dly[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // round to q7 and saturate
    always_comb begin
        w_rq = (AW-9)'((r_roll_dly[N_STAGES-1] + AW'(256)) >>> 9);
        w_pq = (AW-9)'((w_pitch_out.acc + AW'(256)) >>> 9);
        if (w_rq > ROLL_MAX)       w_rs = ROLL_MAX[ROLL_W-1:0];
        else if (w_rq < -ROLL_MAX) w_rs = ROLL_W'(-ROLL_MAX);
        else                       w_rs = w_rq[ROLL_W-1:0];
        if (w_pq > PITCH_MAX)       w_ps = PITCH_MAX[PITCH_W-1:0];
        else if (w_pq < -PITCH_MAX) w_ps = PITCH_W'(-PITCH_MAX);
        else                        w_ps = w_pq[PITCH_W-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_pitch_out.valid;
            r_roll      <= w_rs;
            r_pitch     <= w_ps;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_pitch, r_roll};
endmodule

@@ rtl/core/atrp_cordic.sv @@
`timescale 1ns / 1ps
// unrolled cordic vectoring pipeline, one stage per register
module atrp_cordic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  atrp_pkg::t_cordic i_data,
    output atrp_pkg::t_cordic o_data
);
    import atrp_pkg::*;

    t_cordic r_stage [N_STAGES];
    t_cordic n_stage [N_STAGES];

    // one micro-rotation per stage
    always_comb begin
        for (int i = 0; i < N_STAGES; i++) begin
            t_cordic s;
            t_vec dx;
            t_vec dy;
            s  = (i == 0) ? i_data : r_stage[(i == 0) ? 0 : i - 1];
            dx = s.y >>> i;
            dy = s.x >>> i;
            n_stage[i] = s;
            if (s.x == '0 && s.y == '0) begin
                // zero vector has no angle, keep the start value
                n_stage[i].acc = s.acc;
            end else if (!s.y[DW-1]) begin
                n_stage[i].x   = s.x + dx;
                n_stage[i].y   = s.y - dy;
                n_stage[i].acc = s.acc + atan_q16(STAGE_IDX_W'(i));
            end else begin
                n_stage[i].x   = s.x - dx;
                n_stage[i].y   = s.y + dy;
                n_stage[i].acc = s.acc - atan_q16(STAGE_IDX_W'(i));
            end
        end
    end

    // stage registers advance together when the pipe moves
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_STAGES; i++) begin
            if (!i_rst_n) begin
                r_stage[i].valid <= 1'b0;
            end else if (i_en) begin
                r_stage[i] <= n_stage[i];
            end
        end
    end

    assign o_data = r_stage[N_STAGES-1];
endmodule

@@ rtl/core/atrp_gain.sv @@
`timescale 1ns / 1ps
// gain correction of roll magnitude, setup of pitch pass
module atrp_gain (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  atrp_pkg::t_cordic i_roll,
    input  atrp_pkg::t_vec    i_ax,
    output atrp_pkg::t_cordic o_pitch,
    output atrp_pkg::t_ang    o_roll_acc
);
    import atrp_pkg::*;

    logic signed [DW+17:0] n_prod;
    logic signed [DW+17:0] r_prod;
    logic                  r_valid;
    t_vec                  r_ax;
    t_ang                  r_acc;
    t_vec                  w_mag;

    assign n_prod = i_roll.x * $signed({1'b0, INV_GAIN_Q16});

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_roll.valid;
            r_prod  <= n_prod;
            r_ax    <= i_ax;
            r_acc   <= i_roll.acc;
        end
    end

    // shift and clamp negative to zero
    always_comb begin
        w_mag = DW'(r_prod >>> 16);
        if (w_mag[DW-1]) w_mag = '0;
    end

    assign o_pitch.valid = r_valid;
    assign o_pitch.x     = w_mag;
    assign o_pitch.y     = r_ax;
    assign o_pitch.acc   = '0;
    assign o_roll_acc    = r_acc;
endmodule

@@ rtl/core/atrp_checker.sv @@
`timescale 1ns / 1ps
`include "accel_tilt_roll_pitch_defines.svh"
// port-level checks on the tilt block
module atrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    // a stalled output beat holds
    `ATRP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // input side ready whenever output can move
    `ATRP_ASSERT_IMPL(a_ready, i_clk, i_rst_n, m_axis_tready || !m_axis_tvalid, s_axis_tready)
    // roll stays in range
    `ATRP_ASSERT_IMPL(a_roll, i_clk, i_rst_n, m_axis_tvalid, $signed(m_axis_tdata[15:0]) <= 16'sd23040 && $signed(m_axis_tdata[15:0]) >= -16'sd23040)
    // pitch stays in range
    `ATRP_ASSERT_IMPL(a_pitch, i_clk, i_rst_n, m_axis_tvalid, $signed(m_axis_tdata[30:16]) <= 15'sd11520 && $signed(m_axis_tdata[30:16]) >= -15'sd11520)
endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import atrp_pkg::*;

    localparam int LATENCY    = 2 * N_STAGES + 2;
    localparam int N_RANDOM   = 1500;
    localparam int SAMPLE_MAX = (1 << (SAMPLE_WIDTH - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_WIDTH - 1));

    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic [ROLL_W-1:0]  roll;
    } t_angles;

    // fixed atan table, degrees * 65536
    localparam longint ATAN_DEG[TABLE_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // vectoring pass: drives y to zero, returns angle, leaves gain-scaled magnitude in x
    function automatic longint rotate_to_axis(inout longint x, inout longint y,
                                              input longint ang);
        longint dx, dy;
        for (int i = 0; i < N_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; ang += ATAN_DEG[i];
            end else begin
                x -= dx; y += dy; ang -= ATAN_DEG[i];
            end
        end
        return ang;
    endfunction

    function automatic longint q16_to_q7(longint ang, longint lim);
        longint r;
        r = (ang + 256) >>> 9;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles tilt_angles(logic [SAMPLE_WIDTH-1:0] sx,
                                            logic [SAMPLE_WIDTH-1:0] sy,
                                            logic [SAMPLE_WIDTH-1:0] sz);
        longint ax, ay, az, vx, vy, roll_ang, pitch_ang, mag;
        t_angles r;
        ax = longint'($signed(sx)) <<< (26 - SAMPLE_WIDTH);
        ay = longint'($signed(sy)) <<< (26 - SAMPLE_WIDTH);
        az = longint'($signed(sz)) <<< (26 - SAMPLE_WIDTH);
        roll_ang = 0; pitch_ang = 0; mag = 0;
        if (ay != 0 || az != 0) begin
            roll_ang = 0; vx = az; vy = ay;
            // negative z: pre-rotate by half a turn
            if (az < 0) begin
                roll_ang = (ay >= 0) ? 180 * 65536 : -180 * 65536;
                vx = -az; vy = -ay;
            end
            roll_ang = rotate_to_axis(vx, vy, roll_ang);
            mag = (vx * 39797) >>> 16;
            if (mag < 0) mag = 0;
        end
        if (mag != 0 || ax != 0) begin
            vx = mag; vy = ax;
            pitch_ang = rotate_to_axis(vx, vy, 0);
        end
        r.roll  = ROLL_W'(q16_to_q7(roll_ang, 23040));
        r.pitch = PITCH_W'(q16_to_q7(pitch_ang, 11520));
        return r;
    endfunction

    class angle_scoreboard;
        t_angles pending[$];
        int errors = 0;

        function void note_sample(logic [47:0] d);
            pending.push_back(tilt_angles(d[13:0], d[27:14], d[41:28]));
        endfunction

        function void check_angles(logic [31:0] d);
            t_angles e;
            if (pending.size() == 0) begin
                $error("unexpected output beat %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[15:0] !== e.roll) begin
                $error("roll_angle expected %0d actual %0d",
                       $signed(e.roll), $signed(d[15:0]));
                errors++;
            end
            if (d[30:16] !== e.pitch) begin
                $error("pitch_angle expected %0d actual %0d",
                       $signed(e.pitch), $signed(d[30:16]));
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // accel_x[13:0], accel_y[27:14], accel_z[41:28]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;       // roll_angle[15:0], pitch_angle[30:16]

    angle_scoreboard sb = new();
    bit stim_done = 0;

    accel_tilt_roll_pitch dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // send one sample set after a random gap
    task automatic send_sample(int sx, int sy, int sz);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {6'b0, sz[13:0], sy[13:0], sx[13:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(s_axis_tdata);
        @(negedge i_clk);
    endtask

    function automatic int rand_sample();
        case ($urandom_range(0, 5))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return $urandom_range(0, 6) - 3;
            default: return int'($urandom_range(0, 16383)) + SAMPLE_MIN;
        endcase
    endfunction

    // stimulus
    initial begin
        int pts[6];
        pts = '{0, 1, -1, SAMPLE_MAX, SAMPLE_MIN, 1000};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // zero vector, axis points, extremes, negative z with y zero and with small y of either sign
        send_sample(0, 0, 0);
        send_sample(0, 0, -100);
        send_sample(0, 0, SAMPLE_MIN);
        send_sample(0, 5, -100);
        send_sample(0, -5, -100);
        send_sample(SAMPLE_MAX, 0, 0);
        send_sample(SAMPLE_MIN, 0, 0);
        send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(-1, -1, -1);
        send_sample(1, 0, 1);
        for (int i = 0; i < 6; i++)
            send_sample(pts[i], pts[(i + 2) % 6], pts[(i + 4) % 6]);
        s_axis_tvalid <= 0;
        // hold off until the pipe has drained
        while (sb.pending.size() != 0) @(negedge i_clk);
        for (int n = 0; n < N_RANDOM; n++)
            send_sample(rand_sample(), rand_sample(), rand_sample());
        s_axis_tvalid <= 0;
        stim_done = 1;
    end

    // receiver with random stalls, plus a stall-free stretch
    initial begin
        int stall;
        int beats;
        beats = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = (beats > 600 && beats < 800) ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_axis_tready <= 0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_angles(m_axis_tdata);
            beats++;
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("accel_tilt_roll_pitch verification clean");
        else
            $display("accel_tilt_roll_pitch verification failed");
        $finish;
    end

    // timeout
    initial begin
        #400000;
        $display("accel_tilt_roll_pitch verification failed");
        $finish;
    end
endmodule
